// File: hdl/ecap_pkg.sv
// Shared types, constants and header helpers of the EAPOL capture block.
package ecap_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  frame_byte;
    logic [15:0] frame_length;
    logic        frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       image_last;
    logic       image_empty;
    logic [4:0] frames_held;
  } out_t;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] REG_TIMESTAMP = 2'd0;

  localparam logic [15:0] EAPOL_TYPE     = 16'h888E;
  localparam logic [15:0] HDR_LEN        = 16'd24;
  localparam logic [15:0] LLC_END_PLAIN  = 16'd32;
  localparam logic [15:0] LLC_END_QOS    = 16'd34;
  localparam logic [15:0] ETH_HI_PLAIN   = 16'd30;
  localparam logic [15:0] ETH_HI_QOS     = 16'd32;
  localparam logic [1:0]  FC_TYPE_DATA   = 2'b10;
  localparam logic [31:0] PCAP_MAGIC     = 32'ha1b2c3d4;
  localparam logic [31:0] LINK_80211     = 32'd105;
  localparam logic [4:0]  GLOBAL_HDR_END = 5'd23;
  localparam logic [3:0]  RECORD_HDR_END = 4'd15;

  function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] r;
    r = v[8*k +: 8];
    return r;
  endfunction

  function automatic logic [7:0] global_byte(input logic [4:0] p, input logic [31:0] snap);
    logic [7:0] r;
    if (p < 5'd4) begin
      r = le_byte(PCAP_MAGIC, p[1:0]);
    end else if (p == 5'd4) begin
      r = 8'd2;
    end else if (p == 5'd6) begin
      r = 8'd4;
    end else if (p < 5'd16) begin
      r = 8'd0;
    end else if (p < 5'd20) begin
      r = le_byte(snap, p[1:0]);
    end else begin
      r = le_byte(LINK_80211, p[1:0]);
    end
    return r;
  endfunction

endpackage

// File: hdl/ecap_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ecap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ecap_ingest.sv
// Frame byte filter that decides on EAPOL frames and writes them into slots.
module ecap_ingest #(
  parameter int MAX_FRAMES = 16,
  parameter int SLOT_BYTES = 512,
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1),
  localparam int FI_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int SLOT_W = $clog2(SLOT_BYTES),
  localparam int LEN_W  = $clog2(SLOT_BYTES + 1),
  localparam int ADDR_W = $clog2(MAX_FRAMES * SLOT_BYTES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_en_i,
  input  logic                clear_i,
  input  ecap_pkg::in_t       item_i,
  output logic                store_we_o,
  output logic [ADDR_W-1:0]   store_waddr_o,
  output logic [7:0]          store_wdata_o,
  output logic                len_we_o,
  output logic [FI_W-1:0]     len_waddr_o,
  output logic [LEN_W-1:0]    len_wdata_o,
  output logic [CNT_W-1:0]    held_o
);
  import ecap_pkg::*;

  localparam logic [CNT_W-1:0]  MaxCnt   = CNT_W'(MAX_FRAMES);
  localparam logic [15:0]       SlotLen  = 16'(SLOT_BYTES);
  localparam logic [ADDR_W-1:0] SlotStep = ADDR_W'(SLOT_BYTES);

  logic [CNT_W-1:0]  held_q, held_d;
  logic [ADDR_W-1:0] wbase_q, wbase_d;
  logic [15:0]       idx_q, idx_d;
  logic              dts_q, dts_d;
  logic              qos_q, qos_d;
  logic [15:0]       eth_q, eth_d;
  logic              room, in_range, keep;
  logic [7:0]        b;
  logic [15:0]       flen;

  assign b        = item_i.frame_byte;
  assign flen     = item_i.frame_length;
  assign room     = held_q < MaxCnt;
  assign in_range = room && (idx_q < flen);

  always_comb begin
    dts_d = dts_q;
    qos_d = qos_q;
    eth_d = eth_q;
    if (in_range && idx_q == 16'd0) begin
      dts_d = (b[3:2] == FC_TYPE_DATA);
      qos_d = b[7];
    end
    if (in_range) begin
      if (idx_q == (qos_q ? ETH_HI_QOS : ETH_HI_PLAIN)) begin
        eth_d = {b, eth_q[7:0]};
      end else if (idx_q == (qos_q ? ETH_HI_QOS : ETH_HI_PLAIN) + 16'd1) begin
        eth_d = {eth_q[15:8], b};
      end
    end
  end

  assign keep = room && (flen >= HDR_LEN) && dts_d &&
                (flen >= (qos_d ? LLC_END_QOS : LLC_END_PLAIN)) && (eth_d == EAPOL_TYPE);

  assign store_we_o    = byte_en_i && in_range && (idx_q < SlotLen);
  assign store_waddr_o = wbase_q + ADDR_W'(idx_q[SLOT_W-1:0]);
  assign store_wdata_o = b;
  assign len_we_o      = byte_en_i && item_i.frame_end && keep;
  assign len_waddr_o   = held_q[FI_W-1:0];
  assign len_wdata_o   = (flen > SlotLen) ? LEN_W'(SLOT_BYTES) : flen[LEN_W-1:0];
  assign held_o        = held_q;

  always_comb begin
    held_d  = held_q;
    wbase_d = wbase_q;
    idx_d   = idx_q;
    if (clear_i) begin
      held_d  = '0;
      wbase_d = '0;
      idx_d   = '0;
    end else if (byte_en_i) begin
      idx_d = (idx_q != 16'hFFFF) ? idx_q + 16'd1 : idx_q;
      if (item_i.frame_end) begin
        idx_d = '0;
        if (keep) begin
          held_d  = held_q + CNT_W'(1);
          wbase_d = wbase_q + SlotStep;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      wbase_q <= '0;
      idx_q   <= '0;
      dts_q   <= 1'b0;
      qos_q   <= 1'b0;
      eth_q   <= '0;
    end else begin
      held_q  <= held_d;
      wbase_q <= wbase_d;
      idx_q   <= idx_d;
      if (clear_i || (byte_en_i && item_i.frame_end)) begin
        dts_q <= 1'b0;
        qos_q <= 1'b0;
        eth_q <= '0;
      end else if (byte_en_i) begin
        dts_q <= dts_d;
        qos_q <= qos_d;
        eth_q <= eth_d;
      end
    end
  end

endmodule

// File: hdl/ecap_readout.sv
// Read cursor that walks the PCAP image and forms each image beat.
module ecap_readout #(
  parameter int MAX_FRAMES = 16,
  parameter int SLOT_BYTES = 512,
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1),
  localparam int FI_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int SLOT_W = $clog2(SLOT_BYTES),
  localparam int LEN_W  = $clog2(SLOT_BYTES + 1),
  localparam int ADDR_W = $clog2(MAX_FRAMES * SLOT_BYTES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               step_i,
  input  logic [CNT_W-1:0]   held_i,
  input  logic [31:0]        timestamp_i,
  input  logic [LEN_W-1:0]   len_rdata_i,
  input  logic [7:0]         store_rdata_i,
  output logic [FI_W-1:0]    len_raddr_o,
  output logic [ADDR_W-1:0]  store_raddr_o,
  output ecap_pkg::out_t     result_o
);
  import ecap_pkg::*;

  typedef enum logic [1:0] {SEG_GLOB, SEG_REC, SEG_DATA} seg_e;

  localparam logic [ADDR_W-1:0] SlotStep = ADDR_W'(SLOT_BYTES);

  seg_e              seg_q;
  logic [FI_W-1:0]   fi_q;
  logic [SLOT_W-1:0] off_q;
  logic [ADDR_W-1:0] rbase_q;
  logic              empty, data_end, last_frame, last;
  logic [31:0]       rec_word;
  logic [7:0]        val;

  assign empty      = (held_i == '0);
  assign data_end   = (LEN_W'(off_q) == len_rdata_i - LEN_W'(1));
  assign last_frame = (CNT_W'(fi_q) + CNT_W'(1) == held_i);
  assign last       = !empty && (seg_q == SEG_DATA) && data_end && last_frame;

  always_comb begin
    unique case (off_q[3:2])
      2'd0:    rec_word = timestamp_i;
      2'd1:    rec_word = 32'd0;
      default: rec_word = 32'(len_rdata_i);
    endcase
    unique case (seg_q)
      SEG_GLOB: val = global_byte(off_q[4:0], 32'(SLOT_BYTES));
      SEG_REC:  val = le_byte(rec_word, off_q[1:0]);
      default:  val = store_rdata_i;
    endcase
  end

  assign len_raddr_o   = fi_q;
  assign store_raddr_o = rbase_q + ADDR_W'(off_q);

  always_comb begin
    result_o.image_byte  = empty ? 8'd0 : val;
    result_o.image_last  = last;
    result_o.image_empty = empty;
    result_o.frames_held = 5'(held_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= SEG_GLOB;
      fi_q    <= '0;
      off_q   <= '0;
      rbase_q <= '0;
    end else if (clear_i || (step_i && (empty || last))) begin
      seg_q   <= SEG_GLOB;
      fi_q    <= '0;
      off_q   <= '0;
      rbase_q <= '0;
    end else if (step_i) begin
      unique case (seg_q)
        SEG_GLOB: begin
          if (off_q[4:0] == GLOBAL_HDR_END) begin
            seg_q <= SEG_REC;
            off_q <= '0;
          end else begin
            off_q <= off_q + SLOT_W'(1);
          end
        end
        SEG_REC: begin
          if (off_q[3:0] == RECORD_HDR_END) begin
            seg_q <= SEG_DATA;
            off_q <= '0;
          end else begin
            off_q <= off_q + SLOT_W'(1);
          end
        end
        default: begin
          if (data_end) begin
            seg_q   <= SEG_REC;
            off_q   <= '0;
            fi_q    <= fi_q + FI_W'(1);
            rbase_q <= rbase_q + SlotStep;
          end else begin
            off_q <= off_q + SLOT_W'(1);
          end
        end
      endcase
    end
  end

endmodule

// File: hdl/eapol_frame_capture_pcap.sv
// Top level of the EAPOL frame capture block with PCAP image read-out.
//
// Each input beat carries a request: a received frame byte, a read of the
// next PCAP image byte, or a clear of the capture. Frame bytes are filtered
// on the fly and stored into slots of a byte RAM; a per-slot length RAM
// records each kept frame. Frame bytes can be accepted on every clock while no
// read is in progress. A read issues the RAM reads at the cursor when accepted;
// the READ state then forms the image beat into the output register once it is
// free, limited by the registered read port of the RAMs. Clear and unused
// request codes give no output beat. The output register holds a beat until it
// is taken; frame bytes are still accepted meanwhile unless a read is waiting,
// and a read waits only until the register is free. Reset empties the capture,
// rewinds the read cursor and clears the timestamp register; RAM contents are
// not cleared and need no sweep. The user must write the timestamp register
// over the APB port only while idle; the block itself does not enforce this.
module eapol_frame_capture_pcap #(
  parameter int MAX_FRAMES = 16,
  parameter int SLOT_BYTES = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ecap_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ecap_pkg::out_t   out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ecap_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int FI_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_FRAMES * SLOT_BYTES);

  typedef enum logic {ST_IDLE, ST_READ} state_e;

  state_e            state_q;
  logic              out_valid_q;
  out_t              out_q;
  logic [31:0]       timestamp_q;
  logic              accept, byte_en, clear, step, slot_free;
  logic              store_we, len_we;
  logic [ADDR_W-1:0] store_waddr, store_raddr;
  logic [7:0]        store_wdata, store_rdata;
  logic [FI_W-1:0]   len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata, len_rdata;
  logic [CNT_W-1:0]  held;
  out_t              result;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign byte_en     = accept && (in_data_i.req_type == REQ_BYTE);
  assign clear       = accept && (in_data_i.req_type == REQ_CLEAR);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign step        = (state_q == ST_READ) && slot_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_TIMESTAMP) ? timestamp_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timestamp_q <= '0;
    end else if (psel && penable && pwrite && paddr == REG_TIMESTAMP) begin
      timestamp_q <= pwdata;
    end
  end

  ecap_ingest #(
    .MAX_FRAMES (MAX_FRAMES),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_ingest (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_en_i     (byte_en),
    .clear_i       (clear),
    .item_i        (in_data_i),
    .store_we_o    (store_we),
    .store_waddr_o (store_waddr),
    .store_wdata_o (store_wdata),
    .len_we_o      (len_we),
    .len_waddr_o   (len_waddr),
    .len_wdata_o   (len_wdata),
    .held_o        (held)
  );

  ecap_readout #(
    .MAX_FRAMES (MAX_FRAMES),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_readout (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (clear),
    .step_i        (step),
    .held_i        (held),
    .timestamp_i   (timestamp_q),
    .len_rdata_i   (len_rdata),
    .store_rdata_i (store_rdata),
    .len_raddr_o   (len_raddr),
    .store_raddr_o (store_raddr),
    .result_o      (result)
  );

  ecap_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAMES * SLOT_BYTES)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  ecap_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_FRAMES)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept && in_data_i.req_type == REQ_READ) begin
            state_q <= ST_READ;
          end
        end
        default: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q       <= result;
            state_q     <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: tb/eapol_frame_capture_pcap_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the EAPOL frame capture block and its PCAP image read-out.
module eapol_frame_capture_pcap_tb;
  import ecap_pkg::*;

  localparam int MAX_FRAMES = 16;
  localparam int SLOT_BYTES = 512;
  localparam int MAC_HDR_BYTES = 24;
  localparam int QOS_PAD_BYTES = 2;
  localparam int LLC_SNAP_BYTES = 8;
  localparam int GLOBAL_HDR_BYTES = 24;
  localparam int RECORD_HDR_BYTES = 16;
  localparam int BYTE_POS_MAX = 65535;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] TS_ADDR = 2'(4 * REG_TIMESTAMP);
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TOTAL_ITEMS = 1050;
  localparam longint TIMEOUT_NS = 64'd6_000_000;

  class capture_scoreboard;
    logic [7:0]  slot_mem [MAX_FRAMES*SLOT_BYTES];
    bit          slot_written [MAX_FRAMES*SLOT_BYTES];
    int unsigned slot_len [MAX_FRAMES];
    int unsigned held;
    int unsigned byte_pos;
    bit          is_data;
    bit          is_qos;
    logic [15:0] ethertype = '0;
    int unsigned read_pos;
    logic [31:0] ts_seconds = '0;
    out_t        beats_due [$];
    int unsigned errors;
    int unsigned beats_checked;
    int unsigned frames_kept;

    function bit stores_byte(input in_t it);
      return held < MAX_FRAMES && byte_pos < it.frame_length && byte_pos < SLOT_BYTES;
    endfunction

    // Header flags after this beat, and whether it closes a frame that is kept.
    function void frame_decision(input in_t it, output bit data_n, output bit qos_n,
                                 output logic [15:0] eth_n, output bit keep,
                                 output int unsigned keep_len);
      int unsigned llc;
      data_n = is_data;
      qos_n = is_qos;
      eth_n = ethertype;
      if (held < MAX_FRAMES && byte_pos < it.frame_length) begin
        if (byte_pos == 0) begin
          data_n = (it.frame_byte[3:2] == FC_TYPE_DATA);
          qos_n = it.frame_byte[7];
        end
        llc = MAC_HDR_BYTES + (qos_n ? QOS_PAD_BYTES : 0);
        if (byte_pos == llc + 6) begin
          eth_n[15:8] = it.frame_byte;
        end else if (byte_pos == llc + 7) begin
          eth_n[7:0] = it.frame_byte;
        end
      end
      llc = MAC_HDR_BYTES + (qos_n ? QOS_PAD_BYTES : 0);
      keep = it.frame_end && held < MAX_FRAMES && it.frame_length >= MAC_HDR_BYTES &&
             data_n && it.frame_length >= llc + LLC_SNAP_BYTES && eth_n == EAPOL_TYPE;
      keep_len = (it.frame_length > SLOT_BYTES) ? SLOT_BYTES : it.frame_length;
    endfunction

    // True when keeping this frame would expose slot bytes never written since reset.
    function bit reads_unwritten(input in_t it);
      bit d, q, keep;
      logic [15:0] e;
      int unsigned klen, base, p;
      frame_decision(it, d, q, e, keep, klen);
      if (!keep) return 1'b0;
      base = held * SLOT_BYTES;
      for (p = 0; p < klen; p++) begin
        if (!slot_written[base + p] && !(p == byte_pos && stores_byte(it))) return 1'b1;
      end
      return 1'b0;
    endfunction

    function int unsigned image_length();
      int unsigned total, i;
      total = GLOBAL_HDR_BYTES;
      for (i = 0; i < held; i++) total += RECORD_HDR_BYTES + slot_len[i];
      return total;
    endfunction

    function logic [7:0] image_byte_at(input int unsigned p);
      logic [8*GLOBAL_HDR_BYTES-1:0] ghdr;
      logic [8*RECORD_HDR_BYTES-1:0] rhdr;
      int unsigned rest, i;
      ghdr = {LINK_80211, 32'(SLOT_BYTES), 64'd0, 16'd4, 16'd2, PCAP_MAGIC};
      if (p < GLOBAL_HDR_BYTES) return ghdr[8*p +: 8];
      rest = p - GLOBAL_HDR_BYTES;
      for (i = 0; i < held; i++) begin
        rhdr = {32'(slot_len[i]), 32'(slot_len[i]), 32'd0, ts_seconds};
        if (rest < RECORD_HDR_BYTES) return rhdr[8*rest +: 8];
        rest -= RECORD_HDR_BYTES;
        if (rest < slot_len[i]) return slot_mem[i*SLOT_BYTES + rest];
        rest -= slot_len[i];
      end
      return 8'd0;
    endfunction

    function void restart_frame();
      byte_pos = 0;
      is_data = 1'b0;
      is_qos = 1'b0;
      ethertype = '0;
    endfunction

    function void note_input(input in_t it);
      bit d, q, keep;
      logic [15:0] e;
      int unsigned klen, total;
      out_t beat;
      case (it.req_type)
        REQ_BYTE: begin
          frame_decision(it, d, q, e, keep, klen);
          if (stores_byte(it)) begin
            slot_mem[held*SLOT_BYTES + byte_pos] = it.frame_byte;
            slot_written[held*SLOT_BYTES + byte_pos] = 1'b1;
          end
          is_data = d;
          is_qos = q;
          ethertype = e;
          if (byte_pos < BYTE_POS_MAX) byte_pos++;
          if (it.frame_end) begin
            if (keep) begin
              slot_len[held] = klen;
              held++;
              frames_kept++;
            end
            restart_frame();
          end
        end
        REQ_CLEAR: begin
          held = 0;
          read_pos = 0;
          restart_frame();
        end
        REQ_READ: begin
          beat = '0;
          beat.image_empty = 1'b1;
          beat.frames_held = 5'(held);
          if (held > 0) begin
            total = image_length();
            beat.image_empty = 1'b0;
            if (read_pos >= total) read_pos = 0;
            beat.image_byte = image_byte_at(read_pos);
            if (read_pos + 1 == total) begin
              beat.image_last = 1'b1;
              read_pos = 0;
            end else begin
              read_pos++;
            end
          end else begin
            read_pos = 0;
          end
          beats_due.push_back(beat);
        end
        default: ;
      endcase
    endfunction

    function void check_result(input out_t got);
      out_t want;
      if (beats_due.size() == 0) begin
        $display("%0t: image beat with none due, expected nothing, actual %h", $time, got);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      beats_checked++;
      if (got.image_byte !== want.image_byte) begin
        $display("%0t: image_byte expected %h actual %h", $time, want.image_byte,
                 got.image_byte);
        errors++;
      end
      if (got.image_last !== want.image_last) begin
        $display("%0t: image_last expected %b actual %b", $time, want.image_last,
                 got.image_last);
        errors++;
      end
      if (got.image_empty !== want.image_empty) begin
        $display("%0t: image_empty expected %b actual %b", $time, want.image_empty,
                 got.image_empty);
        errors++;
      end
      if (got.frames_held !== want.frames_held) begin
        $display("%0t: frames_held expected %0d actual %0d", $time, want.frames_held,
                 got.frames_held);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  capture_scoreboard sb;
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;
  bit          partial_ok = 1'b0;
  int unsigned items_sent;
  int unsigned config_count;

  eapol_frame_capture_pcap #(
    .MAX_FRAMES(MAX_FRAMES),
    .SLOT_BYTES(SLOT_BYTES)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_t random_beat(input logic [1:0] req);
    in_t it;
    it.req_type = req;
    it.frame_byte = 8'($urandom);
    it.frame_length = 16'($urandom);
    it.frame_end = 1'($urandom);
    return it;
  endfunction

  task automatic send_beat(input in_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    // A kept frame must never expose slot bytes that were never written.
    if (it.req_type == REQ_BYTE && it.frame_end && !partial_ok && sb.reads_unwritten(it)) begin
      it.frame_length = '0;
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    sb.note_input(it);
  endtask

  task automatic read_burst(input int unsigned n);
    repeat (n) send_beat(random_beat(REQ_READ));
  endtask

  task automatic send_frame(input bit qos, input bit data_type, input bit eapol,
                            input int unsigned flen, input int unsigned nbytes);
    in_t it;
    int unsigned llc, i;
    logic [1:0] fc;
    llc = MAC_HDR_BYTES + (qos ? QOS_PAD_BYTES : 0);
    for (i = 0; i < nbytes; i++) begin
      it.req_type = REQ_BYTE;
      it.frame_byte = 8'($urandom);
      it.frame_length = 16'(flen);
      it.frame_end = (i == nbytes - 1);
      if (i == 0) begin
        fc = 2'($urandom_range(0, 2));
        if (fc == FC_TYPE_DATA) fc = 2'b11;
        it.frame_byte[7] = qos;
        it.frame_byte[3:2] = data_type ? FC_TYPE_DATA : fc;
      end else if (eapol && i == llc + 6) begin
        it.frame_byte = EAPOL_TYPE[15:8];
      end else if (eapol && i == llc + 7) begin
        it.frame_byte = EAPOL_TYPE[7:0];
      end
      send_beat(it);
    end
  endtask

  task automatic set_timestamp(input logic [31:0] secs);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TS_ADDR;
    pwdata <= secs;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.ts_seconds = secs;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== secs) begin
      $display("%0t: timestamp readback expected %h actual %h", $time, secs, prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    config_count++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned stop);
    int unsigned pick, r, qos, llc, flen, nbytes, total, n, i;
    in_t it;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        qos = $urandom_range(0, 1);
        llc = MAC_HDR_BYTES + (qos ? QOS_PAD_BYTES : 0);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          flen = $urandom_range(llc + LLC_SNAP_BYTES, llc + 12);
        end else if (r < 80) begin
          flen = $urandom_range(llc + 13, 120);
        end else if (r < 88) begin
          flen = $urandom_range(MAC_HDR_BYTES, llc + LLC_SNAP_BYTES - 1);
        end else if (r < 94) begin
          flen = $urandom_range(0, MAC_HDR_BYTES - 1);
        end else begin
          flen = $urandom_range(SLOT_BYTES - 8, BYTE_POS_MAX);
        end
        nbytes = flen;
        if (flen > 120 || $urandom_range(0, 6) == 0) nbytes = $urandom_range(1, llc + 14);
        if (nbytes == 0) nbytes = 1;
        send_frame(qos, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, flen, nbytes);
      end else if (pick < 80) begin
        total = sb.image_length();
        if (sb.held != 0 && total <= 400 && $urandom_range(0, 3) == 0) begin
          read_burst(total + $urandom_range(0, 3));
        end else begin
          read_burst($urandom_range(1, 40));
        end
      end else if (pick < 88) begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          it = random_beat(REQ_BYTE);
          if (i == n - 1) it.frame_end = 1'b1;
          send_beat(it);
        end
      end else if (pick < 90 || (pick < 96 && sb.held == MAX_FRAMES)) begin
        send_beat(random_beat(REQ_CLEAR));
      end else if (pick < 97) begin
        send_beat(random_beat(REQ_UNUSED));
      end else begin
        read_burst(1);
      end
    end
  endtask

  initial begin
    sb = new;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_timestamp(32'hFFFF_FFFF);
    read_burst(2);
    send_beat(random_beat(REQ_UNUSED));
    send_beat(random_beat(REQ_CLEAR));
    send_frame(1'b0, 1'b1, 1'b1, MAC_HDR_BYTES + LLC_SNAP_BYTES,
               MAC_HDR_BYTES + LLC_SNAP_BYTES);
    send_frame(1'b1, 1'b1, 1'b1, MAC_HDR_BYTES + QOS_PAD_BYTES + LLC_SNAP_BYTES,
               MAC_HDR_BYTES + QOS_PAD_BYTES + LLC_SNAP_BYTES);
    read_burst(sb.image_length() + 2);
    drain();

    // A frame longer than a slot is held with the slot size; only its written head is read.
    set_timestamp(32'h0);
    send_beat(random_beat(REQ_CLEAR));
    quiet = 1'b1;
    partial_ok = 1'b1;
    send_frame(1'b0, 1'b1, 1'b1, SLOT_BYTES + 40, 40);
    partial_ok = 1'b0;
    read_burst(GLOBAL_HDR_BYTES + RECORD_HDR_BYTES + 40);
    send_beat(random_beat(REQ_CLEAR));
    quiet = 1'b0;

    long_hold = 1'b1;
    send_frame(1'b1, 1'b1, 1'b1, 40, 40);
    read_burst(30);
    drain();

    set_timestamp($urandom);
    random_phase(TOTAL_ITEMS - 450);
    drain();
    set_timestamp($urandom);
    random_phase(TOTAL_ITEMS - 225);
    drain();
    set_timestamp(32'h0000_0001);
    quiet = 1'b1;
    random_phase(TOTAL_ITEMS);
    drain();

    $display("Run kept %0d EAPOL frames over %0d timestamp settings and checked %0d image beats.",
             sb.frames_kept, config_count, sb.beats_checked);
    $display("Stimulus mixed empty reads, clears, unused requests, short frames and a long frame.");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ecap_pkg.sv
hdl/ecap_ram.sv
hdl/ecap_ingest.sv
hdl/ecap_readout.sv
hdl/eapol_frame_capture_pcap.sv
tb/eapol_frame_capture_pcap_tb.sv
